// File: rtl/wsd_pkg.sv
// WebSocket deframer package: result codes, opcodes, length markers, result struct.
// No dependencies.
package wsd_pkg;

  localparam int unsigned LengthBitsDef = 64;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // extended-length / key bytes still to come, minus one
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [3:0] frame_opcode;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

  function automatic logic is_data_op(input logic [3:0] op);
    return (op == OP_TEXT) || (op == OP_BINARY);
  endfunction

endpackage

// File: rtl/wsd_if.sv
// Handshake interfaces for the deframer: received byte channel and result channel.
// Depends on nothing.
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] frame_opcode;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output kind, output frame_opcode, output payload_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input frame_opcode, input payload_byte,
                input last, output ready);
endinterface

// File: rtl/wsd_parser.sv
// Frame parser: header/length/key state and payload unmasking, one byte per step.
// Depends on wsd_pkg.
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  localparam logic [LENGTH_BITS-1:0] LenOne = LENGTH_BITS'(1);

  phase_e                 phase_q, phase_d;
  logic [3:0]             op_q, op_d;
  logic                   mask_q, mask_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [2:0]             hbc_q, hbc_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             pos_q, pos_d;
  logic                   closed_q, closed_d;

  logic       len_done;
  logic       hdr_done;
  logic [7:0] key_byte;
  logic [6:0] len7;

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    mask_d   = mask_q;
    rem_d    = rem_q;
    hbc_d    = hbc_q;
    key_d    = key_q;
    pos_d    = pos_q;
    closed_d = closed_q;
    len_done = 1'b0;
    hdr_done = 1'b0;
    len7     = byte_i[6:0];
    key_byte = 8'd0;
    res_o    = '{valid: 1'b0, kind: KIND_DATA, frame_opcode: 4'd0,
                 payload_byte: 8'd0, last: 1'b0};

    unique case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase

    if (step_i && !closed_q) begin
      unique case (phase_q)
        PH_HDR1: begin
          mask_d = byte_i[7];
          rem_d  = '0;
          if (len7 == LEN7_EXT16) begin
            hbc_d   = EXT16_CNT;
            phase_d = PH_EXT;
          end else if (len7 == LEN7_EXT64) begin
            hbc_d   = EXT64_CNT;
            phase_d = PH_EXT;
          end else begin
            rem_d    = {{(LENGTH_BITS-7){1'b0}}, len7};
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          // saturate once the next shift would overflow
          if (rem_q[LENGTH_BITS-1 -: 8] != 8'd0) rem_d = '1;
          else rem_d = {rem_q[LENGTH_BITS-9:0], byte_i};
          if (hbc_q == 3'd0) len_done = 1'b1;
          else hbc_d = hbc_q - 3'd1;
        end
        PH_KEY: begin
          key_d = {key_q[23:0], byte_i};
          if (hbc_q == 3'd0) hdr_done = 1'b1;
          else hbc_d = hbc_q - 3'd1;
        end
        PH_DATA: begin
          pos_d = pos_q + 2'd1;
          rem_d = rem_q - LenOne;
          if (rem_q == LenOne) phase_d = PH_HDR0;
          if (is_data_op(op_q)) begin
            res_o.valid        = 1'b1;
            res_o.kind         = KIND_DATA;
            res_o.frame_opcode = op_q;
            res_o.payload_byte = byte_i ^ (mask_q ? key_byte : 8'd0);
            res_o.last         = (rem_q == LenOne);
          end
        end
        default: begin
          op_d    = byte_i[3:0];
          phase_d = PH_HDR1;
        end
      endcase

      if (len_done) begin
        if (mask_d) begin
          key_d   = '0;
          hbc_d   = KEY_CNT;
          phase_d = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        if (op_q == OP_CLOSE) begin
          closed_d           = 1'b1;
          phase_d            = PH_HDR0;
          res_o.valid        = 1'b1;
          res_o.kind         = KIND_CLOSE;
          res_o.frame_opcode = op_q;
        end else begin
          pos_d = 2'd0;
          if (rem_d == '0) begin
            phase_d = PH_HDR0;
            if (is_data_op(op_q)) begin
              res_o.valid        = 1'b1;
              res_o.kind         = KIND_EMPTY;
              res_o.frame_opcode = op_q;
              res_o.last         = 1'b1;
            end
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      op_q     <= '0;
      mask_q   <= 1'b0;
      rem_q    <= '0;
      hbc_q    <= '0;
      key_q    <= '0;
      pos_q    <= '0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      mask_q   <= mask_d;
      rem_q    <= rem_d;
      hbc_q    <= hbc_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
      closed_q <= closed_d;
    end
  end

endmodule

// File: rtl/wsd_out_stage.sv
// Result register: holds one result item until the sink takes it.
// Depends on wsd_pkg and wsd_if.
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_t       res_i,
  output logic       free_o,
  wsd_res_if.source  res_o
);

  logic valid_q;
  res_t data_q;

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_i.valid) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.kind         = data_q.kind;
  assign res_o.frame_opcode = data_q.frame_opcode;
  assign res_o.payload_byte = data_q.payload_byte;
  assign res_o.last         = data_q.last;

endmodule

// File: rtl/websocket_frame_deframer_unit.sv
// WebSocket frame deframer top: input byte register, parser, result register.
// Depends on wsd_pkg, wsd_if, wsd_parser, wsd_out_stage.
//
//   channel | dir | payload                                       | handshake
//   rx_i    | in  | rx_byte[7:0]                                  | valid/ready
//   res_o   | out | kind[1:0] frame_opcode[3:0] payload_byte[7:0] | valid/ready
//                   last
//
// One byte per cycle sustained while res_o does not stall; a result reaches res_o through
// the input register, which feeds the parser, and the result register, which holds its output.
// Reset clears all frame state; bytes after a close frame are dropped until reset.
// A stall on res_o holds the result register; the input register still takes one
// more byte if it is empty, then rx_i.ready drops until the result is taken.
module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsd_rx_if.sink    rx_i,
  wsd_res_if.source res_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       step;
  res_t       res;

  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .byte_i(in_byte_q),
    .res_o (res)
  );

  wsd_out_stage u_out (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .res_i (res),
    .free_o(out_free),
    .res_o (res_o)
  );

  // a result produced by the parser lands in the result register
  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.valid |=> res_o.valid)
    else $error("parser result was not captured");

  // input side only stalls when both stages are full and the sink stalls
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> in_valid_q && res_o.valid && !res_o.ready)
    else $error("input stalled without a full pipeline");

  // only payload items carry a byte; close items never flag last
  a_res_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.valid && res.kind != KIND_DATA |->
      res.payload_byte == 8'd0 && (res.kind != KIND_CLOSE || !res.last))
    else $error("non-payload result carries payload fields");

endmodule

// File: tb/sv/websocket_frame_deframer_unit_tb.sv
// Self-checking bench for websocket_frame_deframer_unit: directed byte table, random frames.
// A built-in frame parser computes the results; relies on wsd_pkg and the wsd_if interfaces.
`timescale 1ns / 1ps

module websocket_frame_deframer_unit_tb;
  import wsd_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int CLOSE_ROW    = 29;
  localparam int DIR_ROWS     = 42;

  localparam res_t NO_OUT = '0;

  typedef enum logic [2:0] {
    PH_HEAD0 = 3'd0,
    PH_HEAD1 = 3'd1,
    PH_XLEN  = 3'd2,
    PH_KEYB  = 3'd3,
    PH_BODY  = 3'd4
  } parse_phase_e;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wsd_rx_if  rx_chan();
  wsd_res_if res_chan();

  websocket_frame_deframer_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_chan),
    .res_o (res_chan)
  );

  always #5 clk_i = ~clk_i;

  // parser state, mirrors the frame walk of the block
  parse_phase_e ph        = PH_HEAD0;
  logic [3:0]   cur_op    = '0;
  logic         masked    = 1'b0;
  logic [63:0]  rem_len   = '0;
  logic [2:0]   hdr_left  = '0;
  logic [31:0]  mask_word = '0;
  logic [1:0]   key_pos   = '0;
  bit           seen_close = 1'b0;

  res_t deframed_q[$];
  int   fails        = 0;
  int   results_seen = 0;
  int   bytes_sent   = 0;
  bit   calm         = 1'b0;

  // header, extended length, mask key and payload bytes, then the closing tail (opcode 8 and junk after it)
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'h81, 1'b0, NO_OUT},
    '{8'h00, 1'b1, '{1'b1, KIND_EMPTY, OP_TEXT, 8'h00, 1'b1}},
    '{8'h82, 1'b0, NO_OUT},
    '{8'h80, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'hFF, 1'b1, '{1'b1, KIND_EMPTY, OP_BINARY, 8'h00, 1'b1}},
    '{8'h71, 1'b0, NO_OUT},
    '{8'h01, 1'b0, NO_OUT},
    '{8'hFF, 1'b1, '{1'b1, KIND_DATA, OP_TEXT, 8'hFF, 1'b1}},
    '{8'h82, 1'b0, NO_OUT},
    '{8'h85, 1'b0, NO_OUT},
    '{8'h12, 1'b0, NO_OUT},
    '{8'h34, 1'b0, NO_OUT},
    '{8'h56, 1'b0, NO_OUT},
    '{8'h78, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, NO_OUT},
    '{8'h5A, 1'b0, NO_OUT},
    '{8'hA5, 1'b0, NO_OUT},
    '{8'h12, 1'b0, NO_OUT},
    '{8'h09, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'h02, 1'b0, NO_OUT},
    '{8'h7E, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'h01, 1'b0, NO_OUT},
    '{8'hAB, 1'b1, '{1'b1, KIND_DATA, OP_BINARY, 8'hAB, 1'b1}},
    '{8'h88, 1'b0, NO_OUT},
    '{8'hFE, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'h05, 1'b0, NO_OUT},
    '{8'hDE, 1'b0, NO_OUT},
    '{8'hAD, 1'b0, NO_OUT},
    '{8'hBE, 1'b0, NO_OUT},
    '{8'hEF, 1'b1, '{1'b1, KIND_CLOSE, OP_CLOSE, 8'h00, 1'b0}},
    '{8'h81, 1'b0, NO_OUT},
    '{8'h00, 1'b0, NO_OUT},
    '{8'h82, 1'b0, NO_OUT},
    '{8'h01, 1'b0, NO_OUT},
    '{8'h55, 1'b0, NO_OUT}
  };

  function automatic res_t finish_header();
    res_t r;
    r = '0;
    if (cur_op == OP_CLOSE) begin
      seen_close = 1'b1;
      ph = PH_HEAD0;
      r = '{1'b1, KIND_CLOSE, cur_op, 8'h00, 1'b0};
    end else begin
      key_pos = '0;
      if (rem_len == 0) begin
        ph = PH_HEAD0;
        if (cur_op == OP_TEXT || cur_op == OP_BINARY) begin
          r = '{1'b1, KIND_EMPTY, cur_op, 8'h00, 1'b1};
        end
      end else begin
        ph = PH_BODY;
      end
    end
    return r;
  endfunction

  function automatic res_t finish_length();
    if (masked) begin
      mask_word = '0;
      hdr_left = KEY_CNT;
      ph = PH_KEYB;
      return '0;
    end
    return finish_header();
  endfunction

  // advance the parser by one byte, return the result it causes (valid low if none)
  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t       r;
    logic [7:0] kb;
    r = '0;
    if (seen_close) return r;
    case (ph)
      PH_HEAD1: begin
        masked = b[7];
        rem_len = '0;
        if (b[6:0] == LEN7_EXT16) begin
          hdr_left = EXT16_CNT;
          ph = PH_XLEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          hdr_left = EXT64_CNT;
          ph = PH_XLEN;
        end else begin
          rem_len = 64'(b[6:0]);
          r = finish_length();
        end
      end
      PH_XLEN: begin
        if (rem_len[63:56] != 0) rem_len = '1;
        else rem_len = {rem_len[55:0], b};
        if (hdr_left == 0) r = finish_length();
        else hdr_left = hdr_left - 3'd1;
      end
      PH_KEYB: begin
        mask_word = {mask_word[23:0], b};
        if (hdr_left == 0) r = finish_header();
        else hdr_left = hdr_left - 3'd1;
      end
      PH_BODY: begin
        kb = masked ? mask_word[8 * (3 - key_pos) +: 8] : 8'h00;
        key_pos = key_pos + 2'd1;
        rem_len = rem_len - 64'd1;
        if (rem_len == 0) ph = PH_HEAD0;
        if (cur_op == OP_TEXT || cur_op == OP_BINARY) begin
          r = '{1'b1, KIND_DATA, cur_op, b ^ kb, rem_len == 0};
        end
      end
      default: begin
        cur_op = b[3:0];
        ph = PH_HEAD1;
      end
    endcase
    return r;
  endfunction

  // mostly back-to-back, a few short gaps, rarely a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // keep noise from opening a close frame or a long extended length
  function automatic logic [7:0] tame(input logic [7:0] b);
    logic [7:0] t;
    t = b;
    if (ph == PH_HEAD0 && t[3:0] == OP_CLOSE) t[3] = 1'b0;
    if (ph == PH_HEAD1 && t[6:0] >= LEN7_EXT16) t[6] = 1'b0;
    return t;
  endfunction

  // called at a falling edge, returns at a falling edge after the item is taken
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input res_t want = '0);
    int   gap;
    res_t got;
    gap = idle_gap();
    if (gap > 0) begin
      rx_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_chan.valid   <= 1'b1;
    rx_chan.rx_byte <= b;
    @(posedge clk_i);
    while (rx_chan.ready !== 1'b1) @(posedge clk_i);
    got = deframe_byte(b);
    if (typed) got = want;
    if (got.valid) deframed_q.push_back(got);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    logic [3:0]  op;
    logic [15:0] len;
    logic [31:0] key_v;
    bit          use_mask;
    int          form;
    int          r;
    calm = ($urandom_range(0, 7) == 0);
    r = $urandom_range(0, 99);
    if (r < 45) op = OP_TEXT;
    else if (r < 80) op = OP_BINARY;
    else begin
      op = 4'($urandom_range(0, 15));
      if (op == OP_CLOSE) op = 4'h9;
    end
    r = $urandom_range(0, 99);
    if (r < 10) len = '0;
    else if (r < 75) len = 16'($urandom_range(1, 8));
    else if (r < 93) len = 16'($urandom_range(9, 125));
    else len = 16'($urandom_range(126, 400));
    r = $urandom_range(0, 99);
    if (len > 125 || r < 15) form = (r % 2) + 1;
    else form = 0;
    use_mask = 1'($urandom_range(0, 1));
    key_v = $urandom;
    push_byte({4'($urandom_range(0, 15)), op});
    case (form)
      0: push_byte({use_mask, len[6:0]});
      1: begin
        push_byte({use_mask, LEN7_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        // non-minimal 64-bit length
        push_byte({use_mask, LEN7_EXT64});
        repeat (6) push_byte(8'h00);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
    endcase
    if (use_mask) begin
      for (int k = 0; k < 4; k++) push_byte(key_v[31 - 8 * k -: 8]);
    end
    for (int i = 0; i < len; i++) push_byte(8'($urandom));
  endtask

  task automatic settle_outputs();
    rx_chan.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic compare_deframed();
    res_t w;
    results_seen++;
    if (deframed_q.size() == 0) begin
      $error("unexpected result: kind %0d opcode %0h byte %0h last %0b",
             res_chan.kind, res_chan.frame_opcode, res_chan.payload_byte, res_chan.last);
      fails++;
      return;
    end
    w = deframed_q.pop_front();
    check_field("kind", 8'(w.kind), 8'(res_chan.kind));
    check_field("frame_opcode", 8'(w.frame_opcode), 8'(res_chan.frame_opcode));
    check_field("payload_byte", w.payload_byte, res_chan.payload_byte);
    check_field("last", 8'(w.last), 8'(res_chan.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_chan.valid === 1'b1 && res_chan.ready === 1'b1) compare_deframed();
  end

  // result side: random stalls plus one long hold-off while bytes keep coming
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    res_chan.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        res_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (stall > 0) begin
        res_chan.ready <= 1'b0;
        stall--;
      end else begin
        res_chan.ready <= 1'b1;
        stall = idle_gap();
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL websocket_frame_deframer_unit");
    $finish;
  end

  initial begin
    bit paused;
    int r;
    paused = 1'b0;
    rx_chan.valid   = 1'b0;
    rx_chan.rx_byte = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < CLOSE_ROW; i++) begin
      push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
    end

    while (bytes_sent < CLOSE_ROW + RANDOM_ITEMS) begin
      if (!paused && bytes_sent >= CLOSE_ROW + RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        settle_outputs();
      end
      r = $urandom_range(0, 99);
      if (r < 88) begin
        send_frame();
      end else begin
        // noise, then realign on a frame boundary
        repeat ($urandom_range(1, 6)) push_byte(tame(8'($urandom)));
        while (ph != PH_HEAD0) push_byte(tame(8'($urandom)));
      end
    end

    // close frame with extended length and key; everything after it is dropped
    for (int i = CLOSE_ROW; i < DIR_ROWS; i++) begin
      push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
    end

    settle_outputs();
    repeat (20) @(posedge clk_i);
    if (fails == 0 && deframed_q.size() == 0) begin
      $display("PASS websocket_frame_deframer_unit");
    end else begin
      $display("FAIL websocket_frame_deframer_unit");
    end
    $finish;
  end

endmodule
